>>> sv/rv64_integer_alu_macros.svh
// Assertion helpers used by the checker of the integer execute unit.
`ifndef RV64_INTEGER_ALU_MACROS_SVH
`define RV64_INTEGER_ALU_MACROS_SVH

// Consequent checked at the same edge as the antecedent.
`define RIA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent.
`define RIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ria_pkg.sv
package ria_pkg;

  localparam int unsigned Xlen          = 64;
  localparam int unsigned CmdWidth      = 5;
  localparam int unsigned DefQueueDepth = 2;

  // Operation codes as they arrive on the command field.
  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD    = 5'd0,
    CMD_SUB    = 5'd1,
    CMD_AND    = 5'd2,
    CMD_OR     = 5'd3,
    CMD_XOR    = 5'd4,
    CMD_SLL    = 5'd5,
    CMD_SRL    = 5'd6,
    CMD_SRA    = 5'd7,
    CMD_SLT    = 5'd8,
    CMD_SLTU   = 5'd9,
    CMD_MUL    = 5'd10,
    CMD_MULH   = 5'd11,
    CMD_MULHSU = 5'd12,
    CMD_MULHU  = 5'd13,
    CMD_ANDN   = 5'd14,
    CMD_ORN    = 5'd15,
    CMD_XNOR   = 5'd16,
    CMD_ADDW   = 5'd17,
    CMD_SUBW   = 5'd18,
    CMD_SLLW   = 5'd19,
    CMD_SRLW   = 5'd20,
    CMD_SRAW   = 5'd21,
    CMD_MULW   = 5'd22,
    CMD_ROR    = 5'd23,
    CMD_RORW   = 5'd24
  } cmd_e;

  // Decoded function; word forms share the function and set the word flag.
  typedef enum logic [4:0] {
    FN_NONE,
    FN_ADD,
    FN_SUB,
    FN_AND,
    FN_OR,
    FN_XOR,
    FN_ANDN,
    FN_ORN,
    FN_XNOR,
    FN_SLL,
    FN_SRL,
    FN_SRA,
    FN_ROR,
    FN_SLT,
    FN_SLTU,
    FN_MUL,
    FN_MULH,
    FN_MULHSU,
    FN_MULHU
  } fn_e;

  typedef struct packed {
    fn_e  fn;
    logic word;
    logic illegal;
  } uop_t;

  typedef struct packed {
    uop_t            uop;
    logic [Xlen-1:0] a;
    logic [Xlen-1:0] b;
  } qent_t;

endpackage

>>> sv/ria_front.sv
module ria_front import ria_pkg::*; (
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [CmdWidth-1:0] cmd_i,
  input  logic [Xlen-1:0]     operand_a_i,
  input  logic [Xlen-1:0]     operand_b_i,
  input  logic                q_full_i,
  output logic                push_o,
  output qent_t               entry_o
);

  uop_t uop;

  always_comb begin
    uop = '{fn: FN_NONE, word: 1'b0, illegal: 1'b0};
    case (cmd_i)
      CMD_ADD:    uop.fn = FN_ADD;
      CMD_SUB:    uop.fn = FN_SUB;
      CMD_AND:    uop.fn = FN_AND;
      CMD_OR:     uop.fn = FN_OR;
      CMD_XOR:    uop.fn = FN_XOR;
      CMD_SLL:    uop.fn = FN_SLL;
      CMD_SRL:    uop.fn = FN_SRL;
      CMD_SRA:    uop.fn = FN_SRA;
      CMD_SLT:    uop.fn = FN_SLT;
      CMD_SLTU:   uop.fn = FN_SLTU;
      CMD_MUL:    uop.fn = FN_MUL;
      CMD_MULH:   uop.fn = FN_MULH;
      CMD_MULHSU: uop.fn = FN_MULHSU;
      CMD_MULHU:  uop.fn = FN_MULHU;
      CMD_ANDN:   uop.fn = FN_ANDN;
      CMD_ORN:    uop.fn = FN_ORN;
      CMD_XNOR:   uop.fn = FN_XNOR;
      CMD_ROR:    uop.fn = FN_ROR;
      CMD_ADDW: begin
        uop.fn   = FN_ADD;
        uop.word = 1'b1;
      end
      CMD_SUBW: begin
        uop.fn   = FN_SUB;
        uop.word = 1'b1;
      end
      CMD_SLLW: begin
        uop.fn   = FN_SLL;
        uop.word = 1'b1;
      end
      CMD_SRLW: begin
        uop.fn   = FN_SRL;
        uop.word = 1'b1;
      end
      CMD_SRAW: begin
        uop.fn   = FN_SRA;
        uop.word = 1'b1;
      end
      CMD_MULW: begin
        uop.fn   = FN_MUL;
        uop.word = 1'b1;
      end
      CMD_RORW: begin
        uop.fn   = FN_ROR;
        uop.word = 1'b1;
      end
      default: begin
        uop.illegal = 1'b1;
      end
    endcase
  end

  assign ready_o = !q_full_i;
  assign push_o  = valid_i && !q_full_i;
  assign entry_o = '{uop: uop, a: operand_a_i, b: operand_b_i};

endmodule

>>> sv/ria_queue.sv
module ria_queue import ria_pkg::*; #(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t entry_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qent_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> sv/ria_back.sv
module ria_back import ria_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  qent_t           entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [Xlen-1:0] result_o,
  output logic            illegal_o
);

  localparam int unsigned Half = Xlen / 2;

  function automatic logic [Xlen-1:0] sext_word(logic [Half-1:0] x);
    return {{Half{x[Half-1]}}, x};
  endfunction

  logic adv;

  // Execute stage signals.
  logic [Xlen-1:0]        op_a, op_b;
  logic [5:0]             sh6;
  logic [4:0]             sh5;
  logic                   is_sub;
  logic [Xlen-1:0]        sum;
  logic [Xlen-1:0]        sll64, srl64, ror64;
  logic signed [Xlen-1:0] sra64;
  logic [Half-1:0]        sll32, srl32, ror32;
  logic signed [Half-1:0] sra32;
  logic [Xlen-1:0]        res_d;
  logic [Xlen-1:0]        corr_d;
  logic                   mul_d, hi_d;

  // Pipeline registers.
  logic            s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic [Xlen-1:0] s1_res_q, s2_res_q, s3_res_q;
  logic [Xlen-1:0] s1_corr_q, s2_corr_q, s3_corr_q;
  logic            s1_mul_q, s2_mul_q, s3_mul_q;
  logic            s1_hi_q, s2_hi_q, s3_hi_q;
  logic            s1_word_q, s2_word_q, s3_word_q;
  logic            s1_ill_q, s2_ill_q, s3_ill_q;
  logic [Xlen-1:0] s1_ll_q, s1_lh_q, s1_hl_q, s1_hh_q;
  logic [Xlen-1:0] s2_ll_q, s2_hh_q;
  logic [Xlen:0]   s2_mid_q;
  logic [2*Xlen-1:0] s3_prod_q;
  logic [Xlen-1:0] result_q, result_d;
  logic            illegal_q;

  // The whole back end moves together whenever the output slot is empty or its result is being taken.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv;

  always_comb begin
    op_a   = entry_i.a;
    op_b   = entry_i.b;
    sh6    = op_b[5:0];
    sh5    = op_b[4:0];
    is_sub = (entry_i.uop.fn == FN_SUB);
    sum    = op_a + (is_sub ? ~op_b : op_b) + {{(Xlen-1){1'b0}}, is_sub};
    sll64  = op_a << sh6;
    srl64  = op_a >> sh6;
    sra64  = $signed(op_a) >>> sh6;
    ror64  = (op_a >> sh6) | (op_a << (7'd64 - {1'b0, sh6}));
    sll32  = op_a[Half-1:0] << sh5;
    srl32  = op_a[Half-1:0] >> sh5;
    sra32  = $signed(op_a[Half-1:0]) >>> sh5;
    ror32  = (op_a[Half-1:0] >> sh5) | (op_a[Half-1:0] << (6'd32 - {1'b0, sh5}));

    res_d  = '0;
    mul_d  = 1'b0;
    hi_d   = 1'b0;
    corr_d = '0;
    case (entry_i.uop.fn)
      FN_ADD, FN_SUB: res_d = entry_i.uop.word ? sext_word(sum[Half-1:0]) : sum;
      FN_AND:  res_d = op_a & op_b;
      FN_OR:   res_d = op_a | op_b;
      FN_XOR:  res_d = op_a ^ op_b;
      FN_ANDN: res_d = op_a & ~op_b;
      FN_ORN:  res_d = op_a | ~op_b;
      FN_XNOR: res_d = ~(op_a ^ op_b);
      FN_SLL:  res_d = entry_i.uop.word ? sext_word(sll32) : sll64;
      FN_SRL:  res_d = entry_i.uop.word ? sext_word(srl32) : srl64;
      FN_SRA:  res_d = entry_i.uop.word ? sext_word(sra32) : sra64;
      FN_ROR:  res_d = entry_i.uop.word ? sext_word(ror32) : ror64;
      FN_SLT:  res_d = {{(Xlen-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
      FN_SLTU: res_d = {{(Xlen-1){1'b0}}, (op_a < op_b)};
      FN_MUL: begin
        mul_d = 1'b1;
      end
      FN_MULH: begin
        // Signed high product: subtract each operand where the other is negative.
        mul_d  = 1'b1;
        hi_d   = 1'b1;
        corr_d = (op_a[Xlen-1] ? op_b : '0) + (op_b[Xlen-1] ? op_a : '0);
      end
      FN_MULHSU: begin
        mul_d  = 1'b1;
        hi_d   = 1'b1;
        corr_d = op_a[Xlen-1] ? op_b : '0;
      end
      FN_MULHU: begin
        mul_d = 1'b1;
        hi_d  = 1'b1;
      end
      default: res_d = '0;
    endcase
  end

  always_comb begin
    if (!s3_mul_q) begin
      result_d = s3_res_q;
    end else if (s3_hi_q) begin
      result_d = s3_prod_q[2*Xlen-1:Xlen] - s3_corr_q;
    end else if (s3_word_q) begin
      result_d = sext_word(s3_prod_q[Half-1:0]);
    end else begin
      result_d = s3_prod_q[Xlen-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Execute: logic results and the four 32x32 partial products.
      s1_res_q  <= res_d;
      s1_corr_q <= corr_d;
      s1_mul_q  <= mul_d;
      s1_hi_q   <= hi_d;
      s1_word_q <= entry_i.uop.word;
      s1_ill_q  <= entry_i.uop.illegal;
      s1_ll_q   <= Xlen'(op_a[Half-1:0])    * Xlen'(op_b[Half-1:0]);
      s1_lh_q   <= Xlen'(op_a[Half-1:0])    * Xlen'(op_b[Xlen-1:Half]);
      s1_hl_q   <= Xlen'(op_a[Xlen-1:Half]) * Xlen'(op_b[Half-1:0]);
      s1_hh_q   <= Xlen'(op_a[Xlen-1:Half]) * Xlen'(op_b[Xlen-1:Half]);
      // Sum the cross terms.
      s2_res_q  <= s1_res_q;
      s2_corr_q <= s1_corr_q;
      s2_mul_q  <= s1_mul_q;
      s2_hi_q   <= s1_hi_q;
      s2_word_q <= s1_word_q;
      s2_ill_q  <= s1_ill_q;
      s2_ll_q   <= s1_ll_q;
      s2_hh_q   <= s1_hh_q;
      s2_mid_q  <= {1'b0, s1_lh_q} + {1'b0, s1_hl_q};
      // Assemble the full 128-bit unsigned product.
      s3_res_q  <= s2_res_q;
      s3_corr_q <= s2_corr_q;
      s3_mul_q  <= s2_mul_q;
      s3_hi_q   <= s2_hi_q;
      s3_word_q <= s2_word_q;
      s3_ill_q  <= s2_ill_q;
      s3_prod_q <= {s2_hh_q, s2_ll_q} + {{(Xlen-Half-1){1'b0}}, s2_mid_q, {Half{1'b0}}};
      // Output register: pick the non-multiply result or the product half, and apply the sign correction.
      result_q  <= result_d;
      illegal_q <= s3_ill_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign illegal_o   = illegal_q;

endmodule

>>> sv/rv64_integer_alu.sv
// Channel   Direction  tdata (low bit up)           tuser
// s_axis    in         operand_a[63:0], operand_b   cmd[4:0]
// m_axis    out        result[63:0]                 illegal[0]
//
// One beat is accepted per cycle and one result leaves per cycle when both sides flow.
// From input accept to output valid a beat passes the queue and then the multiplier path:
// partial products, cross-term sum, 128-bit assembly, then the output register.
// All operations share that pipeline, so results leave in order.
// Reset clears the queue and stage valid bits only; payload registers are not reset.
// An output stall freezes the back end; the queue (two entries by default) keeps taking beats until full.
module rv64_integer_alu import ria_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [127:0]  s_axis_tdata_i,   // operand_a [63:0], operand_b [127:64]
  input  logic [4:0]    s_axis_tuser_i,   // cmd [4:0]
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [63:0]   m_axis_tdata_o,   // result [63:0]
  output logic [0:0]    m_axis_tuser_o    // illegal [0]
);

  // Front to queue.
  logic  push;
  logic  q_full;
  qent_t front_entry;

  // Queue to back end.
  logic  q_valid;
  logic  q_pop;
  qent_t q_entry;

  logic  illegal;

  // The front decodes the command into a function class and flags.
  ria_front u_front (
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .operand_a_i (s_axis_tdata_i[63:0]),
    .operand_b_i (s_axis_tdata_i[127:64]),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  // The queue decouples input acceptance from back-end stalls.
  ria_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // The back end executes in a four-stage pipeline ending in the output register.
  ria_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (m_axis_tdata_o),
    .illegal_o   (illegal)
  );

  assign m_axis_tuser_o = illegal;

endmodule

>>> sv/ria_checker.sv
`include "rv64_integer_alu_macros.svh"

module ria_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o,
  input logic [0:0]   m_axis_tuser_o
);

  `RIA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "output beat changed while stalled")

  `RIA_ASSERT_SAME(a_illegal_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == 64'd0, "illegal command produced a nonzero result")

  `RIA_ASSERT_SAME(a_full_on_stall, clk_i, rst_ni, !s_axis_tready_o, $past(m_axis_tvalid_o && !m_axis_tready_i), "input backpressure without an output stall")

endmodule

bind rv64_integer_alu ria_checker u_ria_checker (.*);
